// ===== rtl/mdma_pkg.sv =====
// Package with the shared types, codes and address checks of the DMA scheduler.
`default_nettype none

package mdma_pkg;

  localparam int NumChannelsDef    = 8;
  localparam int BytesPerTickCycle = 64;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_STORE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CHS_IDLE     = 2'd0,
    CHS_RUNNING  = 2'd1,
    CHS_COMPLETE = 2'd2
  } chan_status_e;

  typedef enum logic {
    CS_IDLE,
    CS_SCAN
  } ctrl_state_e;

  typedef struct packed {
    logic        op;
    logic [2:0]  channel;
    logic [31:0] descriptor_pointer;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] length_bytes;
    logic [15:0] flag_bits;
    logic [15:0] elapsed_cycles;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [31:0] burst_source;
    logic [31:0] burst_dest;
    logic [21:0] burst_count;
    logic [31:0] remaining;
    logic [1:0]  channel_status;
    logic        irq_raise;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic store_en;
    logic tick_start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_run;
    logic out_free;
  } dp_status_t;

  function automatic logic addr_is_ram(input logic [31:0] a);
    return (a < 32'h0200_0000)
        || (a >= 32'h0400_0000 && a < 32'h0500_0000)
        || (a >= 32'h0600_0000 && a < 32'h0680_0000)
        || (a >= 32'h0800_0000 && a < 32'h0801_0000)
        || (a >= 32'h0B00_0000 && a < 32'h0B00_8000);
  endfunction

  function automatic logic desc_ok(input logic [31:0] ptr, input logic [31:0] src,
                                   input logic [31:0] dst, input logic [31:0] len,
                                   input logic [15:0] flags);
    return (ptr != 32'd0) && addr_is_ram(ptr) && flags[0] && (len != 32'd0)
        && addr_is_ram(src) && addr_is_ram(dst);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mdma_if.sv =====
// Valid/ready channel interfaces for input items and burst results.
`default_nettype none

interface mdma_in_if import mdma_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mdma_out_if import mdma_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/mdma_ctrl.sv =====
// Controller state machine that sequences stores and the per-channel tick scan.
`default_nettype none

module mdma_ctrl import mdma_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef,
  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_op_i,
  input  wire logic            in_tick_live_i,
  output logic                 in_ready_o,
  input  wire dp_status_t      status_i,
  output dp_cmd_t              cmd_o,
  output logic [IdxW-1:0]      idx_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_CHANNELS - 1);

  ctrl_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            in_take;
  logic            advance;

  assign in_take = in_valid_i && (state_q == CS_IDLE);
  assign advance = !status_i.cur_run || status_i.out_free;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      CS_IDLE: begin
        if (in_take && (in_op_i == OP_TICK) && in_tick_live_i) begin
          state_d = CS_SCAN;
          idx_d   = '0;
        end
      end
      CS_SCAN: begin
        if (advance) begin
          if (idx_q == LastIdx) begin
            state_d = CS_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.store_en   = in_take && (in_op_i == OP_STORE);
        cmd_o.tick_start = in_take && (in_op_i == OP_TICK) && in_tick_live_i;
      end
      CS_SCAN: begin
        cmd_o.emit = status_i.cur_run && status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_start |=> (state_q == CS_SCAN) && (idx_q == '0))
    else $error("Tick did not start the scan at the first channel.");

  a_emit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == CS_SCAN) && !in_ready_o)
    else $error("Burst issued outside the channel scan.");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_SCAN) && (idx_q == LastIdx) && advance |=> (state_q == CS_IDLE))
    else $error("Scan did not end after the last channel.");
`endif

endmodule

`default_nettype wire

// ===== rtl/mdma_dpath.sv =====
// Datapath with descriptor and channel registers, burst arithmetic and the result register.
`default_nettype none

module mdma_dpath import mdma_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef,
  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire in_item_t        in_item_i,
  input  wire dp_cmd_t         cmd_i,
  input  wire logic [IdxW-1:0] idx_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output out_item_t            out_item_o
);

  logic [NUM_CHANNELS-1:0] chan_active_q;
  logic [NUM_CHANNELS-1:0] chan_irq_en_q;
  logic [31:0]             chan_src_q  [NUM_CHANNELS];
  logic [31:0]             chan_dst_q  [NUM_CHANNELS];
  logic [31:0]             chan_left_q [NUM_CHANNELS];
  logic [31:0]             desc_ptr_q  [NUM_CHANNELS];
  logic [31:0]             desc_src_q  [NUM_CHANNELS];
  logic [31:0]             desc_dst_q  [NUM_CHANNELS];
  logic [31:0]             desc_len_q  [NUM_CHANNELS];
  logic [15:0]             desc_flags_q[NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] run_q, run_d;
  logic [31:0]             budget_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    store_hit;
  logic [IdxW-1:0]         store_idx;
  logic                    cur_active;
  logic [31:0]             cur_src, cur_dst, cur_left;
  logic                    cur_irq;
  logic [31:0]             cnt;
  logic [31:0]             new_left;
  logic                    done;
  logic                    is_last;

  assign store_hit = (32'(in_item_i.channel) < NUM_CHANNELS);
  assign store_idx = IdxW'(in_item_i.channel);

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      run_d[c] = chan_active_q[c] || desc_ok(desc_ptr_q[c], desc_src_q[c], desc_dst_q[c],
                                             desc_len_q[c], desc_flags_q[c]);
    end
  end

  assign cur_active = chan_active_q[idx_i];
  assign cur_src    = cur_active ? chan_src_q[idx_i]  : desc_src_q[idx_i];
  assign cur_dst    = cur_active ? chan_dst_q[idx_i]  : desc_dst_q[idx_i];
  assign cur_left   = cur_active ? chan_left_q[idx_i] : desc_len_q[idx_i];
  assign cur_irq    = cur_active ? chan_irq_en_q[idx_i] : desc_flags_q[idx_i][1];
  assign cnt        = (budget_q > cur_left) ? cur_left : budget_q;
  assign new_left   = cur_left - cnt;
  assign done       = (new_left == 32'd0);
  assign is_last    = ((run_q >> idx_i) == NUM_CHANNELS'(1));

  assign status_o.cur_run  = run_q[idx_i];
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_active_q <= '0;
      run_q         <= '0;
      out_valid_q   <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        desc_ptr_q[c] <= '0;
      end
    end else begin
      if (cmd_i.store_en && store_hit) begin
        desc_ptr_q[store_idx] <= in_item_i.descriptor_pointer;
      end
      if (cmd_i.tick_start) begin
        run_q <= run_d;
      end
      if (cmd_i.emit) begin
        chan_active_q[idx_i] <= !done;
        out_valid_q          <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en && store_hit) begin
      desc_src_q[store_idx]   <= in_item_i.source_address;
      desc_dst_q[store_idx]   <= in_item_i.dest_address;
      desc_len_q[store_idx]   <= in_item_i.length_bytes;
      desc_flags_q[store_idx] <= in_item_i.flag_bits;
    end
    if (cmd_i.tick_start) begin
      budget_q <= 32'({16'd0, in_item_i.elapsed_cycles} * 32'(BytesPerTickCycle));
    end
    if (cmd_i.emit) begin
      chan_src_q[idx_i]        <= cur_src + cnt;
      chan_dst_q[idx_i]        <= cur_dst + cnt;
      chan_left_q[idx_i]       <= new_left;
      chan_irq_en_q[idx_i]     <= cur_irq;
      out_q.out_channel        <= 3'(idx_i);
      out_q.burst_source       <= cur_src;
      out_q.burst_dest         <= cur_dst;
      out_q.burst_count        <= cnt[21:0];
      out_q.remaining          <= new_left;
      out_q.channel_status     <= done ? CHS_COMPLETE : CHS_RUNNING;
      out_q.irq_raise          <= done && cur_irq;
      out_q.last               <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i) && run_q[idx_i])
    else $error("Result register overwritten or idle channel reported.");

  a_complete_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.channel_status == CHS_COMPLETE) == (out_q.remaining == 32'd0)))
    else $error("Completion status disagrees with the remaining byte count.");

  a_count_in_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (32'(out_q.burst_count) <= budget_q))
    else $error("Burst count exceeds the tick budget.");
`endif

endmodule

`default_nettype wire

// ===== rtl/multichannel_dma_scheduler.sv =====
// Top level of the eight-channel descriptor DMA scheduler.
//
// Input channel in_i carries store and tick items; output channel out_o carries one
// burst result per running channel on a tick. A transfer happens when valid and
// ready are both high at a rising clock edge.
// A store item writes one channel's descriptor and yields no result.
// A tick item with a nonzero cycle count starts a scan that visits the channels in
// order, starting the cycle after its transfer, one channel per cycle unless a
// running channel waits on the result register. Input ready stays low for the whole
// scan, also while it waits on the receiver. A channel starts there when its
// descriptor qualifies, then reports one burst and advances.
// The first result is registered and appears in the cycle after its channel is
// visited; the final result of the tick has last set.
// Input ready is high only between scans; a tick with zero cycles starts no scan.
// One result register sits on the output: while the receiver stalls, the scan holds
// at the next running channel and resumes once the register is taken.
// Reset clears all channels to idle and all descriptor pointers to zero.
`default_nettype none

module multichannel_dma_scheduler import mdma_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mdma_in_if.sink     in_i,
  mdma_out_if.source  out_o
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [IdxW-1:0] idx;

  mdma_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_op_i        (in_i.payload.op),
    .in_tick_live_i (in_i.payload.elapsed_cycles != 16'd0),
    .in_ready_o     (in_i.ready),
    .status_i       (status),
    .cmd_o          (cmd),
    .idx_o          (idx)
  );

  mdma_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.payload),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

endmodule

`default_nettype wire

// ===== dv/multichannel_dma_scheduler_tb.sv =====
// Self-checking testbench for the eight-channel DMA scheduler, with a directed table and random items.
`default_nettype none

module multichannel_dma_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdma_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int RandomItems = 480;
  localparam int HoldCycles = 400;

  typedef struct {
    in_item_t  item;
    int        n_typed;
    out_item_t typed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mdma_in_if  in_bus ();
  mdma_out_if out_bus ();

  multichannel_dma_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit [31:0] dsc_ptr   [NumChannelsDef];
  bit [31:0] dsc_src   [NumChannelsDef];
  bit [31:0] dsc_dst   [NumChannelsDef];
  bit [31:0] dsc_len   [NumChannelsDef];
  bit [15:0] dsc_flags [NumChannelsDef];
  bit        run_on    [NumChannelsDef];
  bit [31:0] run_src   [NumChannelsDef];
  bit [31:0] run_dst   [NumChannelsDef];
  bit [31:0] run_left  [NumChannelsDef];
  bit        run_irq   [NumChannelsDef];

  out_item_t pending_bursts[$];
  row_t      dir_rows[$];

  int errors = 0;
  int cycle_count = 0;
  int stores_sent = 0;
  int ticks_sent = 0;
  int bursts_checked = 0;
  int completions = 0;
  int irqs_seen = 0;
  bit hold_done = 1'b0;

  function automatic bit [31:0] region_base(int r);
    case (r)
      0: return 32'h0000_0000;
      1: return 32'h0400_0000;
      2: return 32'h0600_0000;
      3: return 32'h0800_0000;
      default: return 32'h0B00_0000;
    endcase
  endfunction

  function automatic bit [31:0] region_size(int r);
    case (r)
      0: return 32'h0200_0000;
      1: return 32'h0100_0000;
      2: return 32'h0080_0000;
      3: return 32'h0001_0000;
      default: return 32'h0000_8000;
    endcase
  endfunction

  function automatic bit in_ram(bit [31:0] a);
    for (int r = 0; r < 5; r++) begin
      if (a >= region_base(r) && (a - region_base(r)) < region_size(r)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_bursts(in_item_t it, ref out_item_t res[$]);
    bit [31:0] budget;
    bit [31:0] cnt;
    int        ch;
    out_item_t b;
    res.delete();
    if (it.op == OP_STORE) begin
      ch = int'(it.channel);
      if (ch < NumChannelsDef) begin
        dsc_ptr[ch]   = it.descriptor_pointer;
        dsc_src[ch]   = it.source_address;
        dsc_dst[ch]   = it.dest_address;
        dsc_len[ch]   = it.length_bytes;
        dsc_flags[ch] = it.flag_bits;
      end
      return;
    end
    budget = 32'(it.elapsed_cycles) * 32'(BytesPerTickCycle);
    if (budget == 0) return;
    for (int c = 0; c < NumChannelsDef; c++) begin
      if (!run_on[c] && dsc_ptr[c] != 0 && in_ram(dsc_ptr[c]) && dsc_flags[c][0]
          && dsc_len[c] != 0 && in_ram(dsc_src[c]) && in_ram(dsc_dst[c])) begin
        run_src[c]  = dsc_src[c];
        run_dst[c]  = dsc_dst[c];
        run_left[c] = dsc_len[c];
        run_irq[c]  = dsc_flags[c][1];
        run_on[c]   = 1'b1;
      end
      if (run_on[c]) begin
        cnt = (budget > run_left[c]) ? run_left[c] : budget;
        b.out_channel  = 3'(c);
        b.burst_source = run_src[c];
        b.burst_dest   = run_dst[c];
        b.burst_count  = cnt[21:0];
        run_src[c]  += cnt;
        run_dst[c]  += cnt;
        run_left[c] -= cnt;
        b.remaining = run_left[c];
        if (run_left[c] == 0) begin
          run_on[c]        = 1'b0;
          b.channel_status = CHS_COMPLETE;
          b.irq_raise      = run_irq[c];
        end else begin
          b.channel_status = CHS_RUNNING;
          b.irq_raise      = 1'b0;
        end
        b.last = 1'b0;
        res.push_back(b);
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op                 = 1'($urandom);
    it.channel            = 3'($urandom);
    it.descriptor_pointer = $urandom;
    it.source_address     = $urandom;
    it.dest_address       = $urandom;
    it.length_bytes       = $urandom;
    it.flag_bits          = 16'($urandom);
    it.elapsed_cycles     = 16'($urandom);
    return it;
  endfunction

  function automatic bit [31:0] ram_addr();
    int r;
    r = $urandom_range(0, 4);
    case ($urandom_range(0, 7))
      0: return region_base(r);
      1: return region_base(r) + region_size(r) - 1;
      default: return region_base(r) + ($urandom % region_size(r));
    endcase
  endfunction

  function automatic in_item_t next_random_item();
    in_item_t it;
    int       pick;
    it = random_item();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.op = OP_STORE;
      it.descriptor_pointer = ram_addr();
      if (it.descriptor_pointer == 0) it.descriptor_pointer = 32'h40;
      it.source_address = ram_addr();
      it.dest_address = ram_addr();
      it.length_bytes = ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(1, 1500);
      it.flag_bits[0] = 1'b1;
    end else if (pick < 85) begin
      it.op = OP_TICK;
      it.elapsed_cycles = 16'($urandom_range(1, 8));
    end else if (pick < 92) begin
      it.op = OP_TICK;
    end else begin
      it.op = OP_STORE;
    end
    return it;
  endfunction

  function automatic in_item_t mk_store(int ch, bit [31:0] ptr, bit [31:0] src, bit [31:0] dst,
                                        bit [31:0] len, bit [15:0] flags);
    in_item_t it;
    it = '0;
    it.op = OP_STORE;
    it.channel = 3'(ch);
    it.descriptor_pointer = ptr;
    it.source_address = src;
    it.dest_address = dst;
    it.length_bytes = len;
    it.flag_bits = flags;
    return it;
  endfunction

  function automatic in_item_t mk_tick(bit [15:0] cycles);
    in_item_t it;
    it = '0;
    it.op = OP_TICK;
    it.elapsed_cycles = cycles;
    return it;
  endfunction

  function automatic out_item_t mk_burst(int ch, bit [31:0] src, bit [31:0] dst, bit [21:0] cnt,
                                         bit [31:0] rem, chan_status_e st, bit irq);
    out_item_t b;
    b.out_channel    = 3'(ch);
    b.burst_source   = src;
    b.burst_dest     = dst;
    b.burst_count    = cnt;
    b.remaining      = rem;
    b.channel_status = st;
    b.irq_raise      = irq;
    b.last           = 1'b1;
    return b;
  endfunction

  function automatic void add_row(in_item_t it, int n, out_item_t b);
    row_t r;
    r.item = it;
    r.n_typed = n;
    r.typed = b;
    dir_rows.push_back(r);
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_item(in_item_t it, int n_typed, out_item_t typed);
    out_item_t res[$];
    bit        fire;
    in_bus.valid   <= 1'b1;
    in_bus.payload <= it;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk_i);
      fire = (in_bus.ready === 1'b1);
      @(posedge clk_i);
    end
    predict_bursts(it, res);
    if (n_typed < 0) begin
      foreach (res[i]) pending_bursts.push_back(res[i]);
    end else if (n_typed == 1) begin
      pending_bursts.push_back(typed);
    end
    if (it.op == OP_STORE) stores_sent++;
    else ticks_sent++;
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_burst(out_item_t got);
    out_item_t want;
    if (pending_bursts.size() == 0) begin
      $display("%0t: unexpected burst, expected none, actual channel %0d count %0d",
               $time, got.out_channel, got.burst_count);
      errors++;
      return;
    end
    want = pending_bursts.pop_front();
    cmp_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
    cmp_field("burst_source", want.burst_source, got.burst_source);
    cmp_field("burst_dest", want.burst_dest, got.burst_dest);
    cmp_field("burst_count", 32'(want.burst_count), 32'(got.burst_count));
    cmp_field("remaining", want.remaining, got.remaining);
    cmp_field("channel_status", 32'(want.channel_status), 32'(got.channel_status));
    cmp_field("irq_raise", 32'(want.irq_raise), 32'(got.irq_raise));
    cmp_field("last", 32'(want.last), 32'(got.last));
    bursts_checked++;
    if (got.channel_status == CHS_COMPLETE) completions++;
    if (got.irq_raise) irqs_seen++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      check_burst(out_bus.payload);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d bursts outstanding", $time, pending_bursts.size());
      $display("multichannel_dma_scheduler test failed");
      $finish;
    end
  end

  initial begin
    int stall_left;
    int rx_cycles;
    bit rx_calm;
    stall_left = 0;
    rx_cycles = 0;
    rx_calm = 1'b0;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rx_cycles % 500 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (!hold_done && bursts_checked >= 60) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin
    in_item_t it;
    int       gap;
    bit       tx_calm;
    tx_calm = 1'b0;
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.payload <= '0;

    add_row(mk_tick(16'd1), 0, '0);
    add_row(mk_tick(16'd0), 0, '0);
    add_row(mk_store(0, 32'h1000, 32'h100, 32'h0400_0000, 32'd100, 16'h0003), 0, '0);
    add_row(mk_tick(16'd1), 1,
            mk_burst(0, 32'h100, 32'h0400_0000, 22'd64, 32'd36, CHS_RUNNING, 1'b0));
    add_row(mk_tick(16'd0), 0, '0);
    add_row(mk_tick(16'hFFFF), 1,
            mk_burst(0, 32'h140, 32'h0400_0040, 22'd36, 32'd0, CHS_COMPLETE, 1'b1));
    add_row(mk_tick(16'd1), -1, '0);
    add_row(mk_store(7, '1, '1, '1, '1, 16'hFFFF), 0, '0);
    add_row(mk_store(0, 32'h0, 32'h100, 32'h100, 32'd10, 16'h0001), 0, '0);
    add_row(mk_tick(16'd1), -1, '0);
    add_row(mk_store(1, 32'h0B00_7FFF, 32'h01FF_FFFF, 32'h0800_FFFF, 32'h0040_0000, 16'h0001),
            0, '0);
    add_row(mk_store(2, 32'h0400_0000, 32'h067F_FFFF, 32'h0600_0000, 32'd1, 16'h0006), 0, '0);
    add_row(mk_store(3, 32'h0500_0000, 32'h100, 32'h100, 32'd5, 16'h0003), 0, '0);
    add_row(mk_store(4, 32'h100, 32'h0200_0000, 32'h100, 32'd5, 16'h0003), 0, '0);
    add_row(mk_store(5, 32'h100, 32'h100, 32'h0680_0000, 32'd5, 16'h0003), 0, '0);
    add_row(mk_store(6, 32'h100, 32'h0801_0000, 32'h100, 32'd5, 16'h0003), 0, '0);
    add_row(mk_tick(16'hFFFF), 1,
            mk_burst(1, 32'h01FF_FFFF, 32'h0800_FFFF, 22'h3F_FFC0, 32'h40, CHS_RUNNING, 1'b0));
    add_row(mk_store(3, 32'h0B00_0000, 32'h0B00_7FFF, 32'h067F_FFFF, 32'd3, 16'hFFFF), 0, '0);
    add_row(mk_store(6, 32'h0800_FFFF, 32'h04FF_FFFF, 32'h0, 32'h80, 16'h0002), 0, '0);
    add_row(mk_tick(16'd2), -1, '0);
    add_row(mk_store(2, 32'h01FF_FFFF, 32'h0600_0000, 32'h0400_0000, 32'd200, 16'h0003), 0, '0);
    add_row(mk_store(5, 32'h0800_0000, 32'h0B00_0000, 32'h04FF_FFFF, 32'd100, 16'h0001), 0, '0);
    add_row(mk_tick(16'd1), -1, '0);
    add_row(mk_tick(16'hFFFF), -1, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].n_typed, dir_rows[i].typed);
      gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 60 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      it = next_random_item();
      send_item(it, -1, '0);
      gap = (!tx_calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0 || n == RandomItems - 1) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    while (pending_bursts.size() != 0) @(posedge clk_i);
    repeat (2 * NumChannelsDef + 4) @(posedge clk_i);

    $display("Covered %0d descriptor stores and %0d ticks, with %0d bursts checked.",
             stores_sent, ticks_sent, bursts_checked);
    $display("%0d transfers completed, %0d of them raising an interrupt; %0d mismatches.",
             completions, irqs_seen, errors);
    if (errors == 0) begin
      $display("multichannel_dma_scheduler test passed");
    end else begin
      $display("multichannel_dma_scheduler test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
